// ===== rtl/lbe_pkg.sv =====
// shared constants and codes for the life board engine
package lbe_pkg;

   // board geometry and pixel scaling
   localparam int BOARD_SIZE  = 64;
   localparam int CELL_PIXELS = 5;
   localparam int ROW_AW      = $clog2(BOARD_SIZE);

   // request and response field widths
   localparam int ACTION_W = 2;
   localparam int PIXEL_W  = 9;
   localparam int OUT_W    = 64;

   // columns shown on the response row
   localparam int ROW_SHOW = (BOARD_SIZE < OUT_W) ? BOARD_SIZE : OUT_W;

   // sweep counter runs 0 .. BOARD_SIZE + 1 during a sweep
   localparam int CNT_W = $clog2(BOARD_SIZE + 2);

   // pixel to cell index: floor((p - 1) / CELL_PIXELS) by reciprocal multiply
   localparam int DIV_SHIFT = 16;
   localparam int RECIP_W   = DIV_SHIFT + 1;
   localparam logic [RECIP_W-1:0] DIV_RECIP =
      RECIP_W'((2 ** DIV_SHIFT) / CELL_PIXELS + 1);
   localparam int MUL_W = PIXEL_W + RECIP_W;
   localparam logic [PIXEL_W:0] IDX_LIMIT = (PIXEL_W + 1)'(BOARD_SIZE);

   // action codes
   localparam logic [ACTION_W-1:0] ACT_TOGGLE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_STEP   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

endpackage

// ===== rtl/life_board_engine.sv =====
// top level of the life board engine: sequencer, board memory and response register
//
// life board engine: a BOARD_SIZE x BOARD_SIZE board of one-bit cells under the
// B3/S23 rule, with the grid edge treated as dead cells. each request carries an
// action and two pixel coordinates; a coordinate p selects cell ceil(p/CELL_PIXELS)-1,
// and zero or a value past the board selects nothing. toggle inverts the addressed
// cell, step advances the whole board one generation, read only looks. every request
// gives exactly one response: the row selected by pixel_y after the action (zero if
// pixel_y selects no row) and an accepted flag. the block takes one request at a time.
// a request passes the pixel decoder (one shared reciprocal multiplier, x then y),
// then fetches the row from the board memory and is handed off to the response
// register, going through the states decode x, decode y, fetch, load and done. the
// hand-off waits while the response register still holds a response not yet taken,
// and req_ready comes back together with the response. a toggle or read whose pixel_y
// selects no row, and the unused action code, skip the fetch and go from decode y
// straight to done. step adds a sweep of the whole board: the single read port of the
// board memory delivers one row a cycle into two line buffers, and one shared row
// rule unit writes back each row after the row below it is read; a step whose pixel_y
// selects no row also skips the fetch. after reset the board reads as all dead at
// once through per-row valid bits, no clearing pass. a finished response waits in its
// own register, so the next request is taken while the previous response is still pending on the rsp side.
module life_board_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lbe_pkg::ACTION_W-1:0]  req_action,
   input  logic [lbe_pkg::PIXEL_W-1:0]   req_pixel_x,
   input  logic [lbe_pkg::PIXEL_W-1:0]   req_pixel_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lbe_pkg::OUT_W-1:0]     rsp_row_bits,
   output logic                          rsp_accepted
);
   import lbe_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_DEC_X = 7'b0000010,
      ST_DEC_Y = 7'b0000100,
      ST_STEP  = 7'b0001000,
      ST_FETCH = 7'b0010000,
      ST_LOAD  = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   // sequencer state
   state_type             state_ff, state_in;
   logic [ACTION_W-1:0]   action_ff, action_in;
   logic [PIXEL_W-1:0]    px_ff, px_in;
   logic [PIXEL_W-1:0]    py_ff, py_in;
   logic [ROW_AW-1:0]     col_ff, col_in;
   logic                  col_ok_ff, col_ok_in;
   logic [ROW_AW-1:0]     row_ff, row_in;
   logic                  row_ok_ff, row_ok_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   // line buffers: old contents of the row above and of the current row
   logic [BOARD_SIZE-1:0] above_ff, above_in;
   logic [BOARD_SIZE-1:0] cur_ff, cur_in;

   // finished result and response register
   logic [BOARD_SIZE-1:0] res_bits_ff, res_bits_in;
   logic                  res_acc_ff, res_acc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]      rsp_bits_ff, rsp_bits_in;
   logic                  rsp_acc_ff, rsp_acc_in;

   // board memory with per-row valid bits
   logic [BOARD_SIZE-1:0] board_mem [BOARD_SIZE];
   logic [BOARD_SIZE-1:0] row_valid_ff;
   logic [BOARD_SIZE-1:0] rd_data_ff;
   logic                  rd_live_ff;
   logic [ROW_AW-1:0]     rd_addr;
   logic [BOARD_SIZE-1:0] rd_row;
   logic                  mem_we;
   logic [ROW_AW-1:0]     wr_addr;
   logic [BOARD_SIZE-1:0] wr_data;

   // shared pixel decoder
   logic [PIXEL_W-1:0]    dec_pix;
   logic [PIXEL_W-1:0]    dec_pix_m1;
   logic [MUL_W-1:0]      dec_prod;
   logic [PIXEL_W-1:0]    dec_idx;
   logic                  dec_ok;

   // sweep control
   logic                  sweep_last;
   logic                  shift_en;
   logic                  step_wr;
   logic [CNT_W-1:0]      step_row;
   logic [BOARD_SIZE-1:0] below_row;
   logic [BOARD_SIZE-1:0] next_row;
   logic                  do_tgl;
   logic [BOARD_SIZE-1:0] tgl_row;

   // one multiplier decodes x in ST_DEC_X and y in ST_DEC_Y
   assign dec_pix    = (state_ff == ST_DEC_X) ? px_ff : py_ff;
   assign dec_pix_m1 = dec_pix - PIXEL_W'(1);
   assign dec_prod   = MUL_W'(dec_pix_m1) * MUL_W'(DIV_RECIP);
   assign dec_idx    = dec_prod[DIV_SHIFT +: PIXEL_W];
   assign dec_ok     = (dec_pix != '0) && ({1'b0, dec_idx} < IDX_LIMIT);

   // rows never written read as dead
   assign rd_row = rd_live_ff ? rd_data_ff : '0;

   // sweep: read row cnt, shift row cnt-1 into the buffers, write row cnt-2
   assign sweep_last = (cnt_ff == CNT_W'(BOARD_SIZE + 1));
   assign shift_en   = (state_ff == ST_STEP) && (cnt_ff != '0) && !sweep_last;
   assign step_wr    = (state_ff == ST_STEP) && (cnt_ff >= CNT_W'(2));
   assign step_row   = cnt_ff - CNT_W'(2);
   assign below_row  = sweep_last ? '0 : rd_row;

   lbe_row_unit u_row_unit (
      .above    (above_ff),
      .cur      (cur_ff),
      .below    (below_row),
      .next_row (next_row)
   );

   // toggle rewrites the fetched row with one bit inverted
   assign do_tgl  = (state_ff == ST_LOAD) && (action_ff == ACT_TOGGLE) && col_ok_ff;
   assign tgl_row = rd_row ^ (BOARD_SIZE'(1) << col_ff);

   assign rd_addr = (state_ff == ST_STEP) ? cnt_ff[ROW_AW-1:0] : row_ff;
   assign mem_we  = step_wr || do_tgl;
   assign wr_addr = step_wr ? step_row[ROW_AW-1:0] : row_ff;
   assign wr_data = step_wr ? next_row : tgl_row;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         board_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= board_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_live_ff   <= 1'b0;
      end else begin
         if (mem_we) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         rd_live_ff <= row_valid_ff[rd_addr];
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      col_in       = col_ff;
      col_ok_in    = col_ok_ff;
      row_in       = row_ff;
      row_ok_in    = row_ok_ff;
      cnt_in       = cnt_ff;
      above_in     = above_ff;
      cur_in       = cur_ff;
      res_bits_in  = res_bits_ff;
      res_acc_in   = res_acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_bits_in  = rsp_bits_ff;
      rsp_acc_in   = rsp_acc_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               action_in = req_action;
               px_in     = req_pixel_x;
               py_in     = req_pixel_y;
               state_in  = ST_DEC_X;
            end
         end
         ST_DEC_X: begin
            col_in    = dec_idx[ROW_AW-1:0];
            col_ok_in = dec_ok;
            state_in  = ST_DEC_Y;
         end
         ST_DEC_Y: begin
            row_in    = dec_idx[ROW_AW-1:0];
            row_ok_in = dec_ok;
            // default: no row selected, or unused action code
            res_bits_in = '0;
            res_acc_in  = 1'b0;
            state_in    = ST_DONE;
            if (action_ff == ACT_STEP) begin
               cnt_in   = '0;
               above_in = '0;
               cur_in   = '0;
               state_in = ST_STEP;
            end else if ((action_ff == ACT_TOGGLE) || (action_ff == ACT_READ)) begin
               if (dec_ok) begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_STEP: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (shift_en) begin
               above_in = cur_ff;
               cur_in   = rd_row;
            end
            if (sweep_last) begin
               if (row_ok_ff) begin
                  state_in = ST_FETCH;
               end else begin
                  res_bits_in = '0;
                  res_acc_in  = 1'b0;
                  state_in    = ST_DONE;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            res_bits_in = do_tgl ? tgl_row : rd_row;
            res_acc_in  = (action_ff == ACT_TOGGLE) ? col_ok_ff : 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            // hand off once the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_bits_in  = OUT_W'(res_bits_ff[ROW_SHOW-1:0]);
               rsp_acc_in   = res_acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      col_ff      <= col_in;
      col_ok_ff   <= col_ok_in;
      row_ff      <= row_in;
      row_ok_ff   <= row_ok_in;
      above_ff    <= above_in;
      cur_ff      <= cur_in;
      res_bits_ff <= res_bits_in;
      res_acc_ff  <= res_acc_in;
      rsp_bits_ff <= rsp_bits_in;
      rsp_acc_ff  <= rsp_acc_in;
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_row_bits = rsp_bits_ff;
   assign rsp_accepted = rsp_acc_ff;

`ifndef SYNTHESIS
   // the board is written only by the sweep or by a toggle write-back
   a_we_phase: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((state_ff == ST_STEP) || (state_ff == ST_LOAD)))
      else $error("board written outside sweep or toggle");

   // a taken request closes the input until its response is handed off
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   // a new response only comes out of the hand-off state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside hand-off");

   // the sweep ends right after its last row is written
   a_sweep_end: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_STEP) && sweep_last) |=> (state_ff != ST_STEP))
      else $error("sweep ran past the last row");
`endif

endmodule

// ===== rtl/lbe_row_unit.sv =====
// next-generation rule for one board row from the row itself and the rows above and below
module lbe_row_unit (
   input  logic [lbe_pkg::BOARD_SIZE-1:0] above,
   input  logic [lbe_pkg::BOARD_SIZE-1:0] cur,
   input  logic [lbe_pkg::BOARD_SIZE-1:0] below,
   output logic [lbe_pkg::BOARD_SIZE-1:0] next_row
);
   import lbe_pkg::*;

   // one dead cell padded on each side of every row
   logic [BOARD_SIZE+1:0] above_pad;
   logic [BOARD_SIZE+1:0] cur_pad;
   logic [BOARD_SIZE+1:0] below_pad;

   assign above_pad = {1'b0, above, 1'b0};
   assign cur_pad   = {1'b0, cur, 1'b0};
   assign below_pad = {1'b0, below, 1'b0};

   always_comb begin
      logic [3:0] n;
      for (int c = 0; c < BOARD_SIZE; c++) begin
         n = 4'(above_pad[c]) + 4'(above_pad[c+1]) + 4'(above_pad[c+2])
           + 4'(cur_pad[c])                        + 4'(cur_pad[c+2])
           + 4'(below_pad[c]) + 4'(below_pad[c+1]) + 4'(below_pad[c+2]);
         // birth on three, survival on two or three
         next_row[c] = (n == 4'd3) || (cur[c] && (n == 4'd2));
      end
   end

endmodule
